>>> design/qrot_pkg.sv
// qrot_pkg: payload types and constants for the quaternion point rotation pipeline
// used by every module of the block; no dependencies
`default_nettype none

package qrot_pkg;

   localparam int QuatWidth  = 16;
   localparam int PointWidth = 32;
   localparam int ProdWidth  = 32;
   localparam int CoefWidth  = 32;
   localparam int TermWidth  = 64;
   localparam int FracShift  = 28;
   localparam int RoundWidth = TermWidth + 1 - FracShift;

   localparam logic signed [QuatWidth-1:0] QUAT_ONE     = 16'sd16384;
   localparam logic signed [QuatWidth-1:0] QUAT_NEG_ONE = -16'sd16384;
   localparam logic signed [TermWidth:0]   ROUND_HALF   = 65'sd134217728;
   localparam logic [PointWidth-1:0]       POINT_MAX    = 32'h7fff_ffff;
   localparam logic [PointWidth-1:0]       POINT_MIN    = 32'h8000_0000;

   typedef struct packed {
      logic signed [PointWidth-1:0] pz;
      logic signed [PointWidth-1:0] py;
      logic signed [PointWidth-1:0] px;
      logic signed [QuatWidth-1:0]  qw;
      logic signed [QuatWidth-1:0]  qz;
      logic signed [QuatWidth-1:0]  qy;
      logic signed [QuatWidth-1:0]  qx;
   } req_type;

   typedef struct packed {
      logic signed [ProdWidth-1:0]  xx;
      logic signed [ProdWidth-1:0]  yy;
      logic signed [ProdWidth-1:0]  zz;
      logic signed [ProdWidth-1:0]  ww;
      logic signed [ProdWidth-1:0]  xy;
      logic signed [ProdWidth-1:0]  xz;
      logic signed [ProdWidth-1:0]  yz;
      logic signed [ProdWidth-1:0]  wx;
      logic signed [ProdWidth-1:0]  wy;
      logic signed [ProdWidth-1:0]  wz;
      logic signed [PointWidth-1:0] px;
      logic signed [PointWidth-1:0] py;
      logic signed [PointWidth-1:0] pz;
   } prod_type;

   typedef struct packed {
      logic signed [CoefWidth-1:0]  m00;
      logic signed [CoefWidth-1:0]  m01;
      logic signed [CoefWidth-1:0]  m02;
      logic signed [CoefWidth-1:0]  m10;
      logic signed [CoefWidth-1:0]  m11;
      logic signed [CoefWidth-1:0]  m12;
      logic signed [CoefWidth-1:0]  m20;
      logic signed [CoefWidth-1:0]  m21;
      logic signed [CoefWidth-1:0]  m22;
      logic signed [PointWidth-1:0] px;
      logic signed [PointWidth-1:0] py;
      logic signed [PointWidth-1:0] pz;
   } coef_type;

   typedef struct packed {
      logic signed [TermWidth-1:0] t00;
      logic signed [TermWidth-1:0] t01;
      logic signed [TermWidth-1:0] t02;
      logic signed [TermWidth-1:0] t10;
      logic signed [TermWidth-1:0] t11;
      logic signed [TermWidth-1:0] t12;
      logic signed [TermWidth-1:0] t20;
      logic signed [TermWidth-1:0] t21;
      logic signed [TermWidth-1:0] t22;
   } term_type;

   typedef struct packed {
      logic signed [TermWidth-1:0] sx;
      logic signed [TermWidth-1:0] sy;
      logic signed [TermWidth-1:0] sz;
   } sum_type;

   typedef struct packed {
      logic                         sat;
      logic signed [PointWidth-1:0] rz;
      logic signed [PointWidth-1:0] ry;
      logic signed [PointWidth-1:0] rx;
   } rsp_type;

   function automatic logic signed [QuatWidth-1:0] clamp_quat(
      input logic signed [QuatWidth-1:0] q);
      logic signed [QuatWidth-1:0] r;
      r = q;
      if (q > QUAT_ONE) begin
         r = QUAT_ONE;
      end else if (q < QUAT_NEG_ONE) begin
         r = QUAT_NEG_ONE;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> design/qrot_coef.sv
// qrot_coef: clamps the quaternion, forms its ten pairwise products and the rotation matrix
// three register stages; depends on qrot_pkg
`default_nettype none

module qrot_coef import qrot_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  wire req_type in_data,
   output logic      out_valid,
   input  wire logic out_ready,
   output coef_type  out_data
);

   logic [2:0] valid_ff;
   logic [2:0] adv;

   req_type  clamp_ff, clamp_in;
   prod_type prod_ff, prod_in;
   coef_type coef_ff, coef_in;

   assign adv[2]   = !valid_ff[2] || out_ready;
   assign adv[1]   = !valid_ff[1] || adv[2];
   assign adv[0]   = !valid_ff[0] || adv[1];
   assign in_ready = adv[0];

   always_comb begin
      clamp_in    = in_data;
      clamp_in.qx = clamp_quat(in_data.qx);
      clamp_in.qy = clamp_quat(in_data.qy);
      clamp_in.qz = clamp_quat(in_data.qz);
      clamp_in.qw = clamp_quat(in_data.qw);
   end

   always_comb begin
      prod_in.xx = clamp_ff.qx * clamp_ff.qx;
      prod_in.yy = clamp_ff.qy * clamp_ff.qy;
      prod_in.zz = clamp_ff.qz * clamp_ff.qz;
      prod_in.ww = clamp_ff.qw * clamp_ff.qw;
      prod_in.xy = clamp_ff.qx * clamp_ff.qy;
      prod_in.xz = clamp_ff.qx * clamp_ff.qz;
      prod_in.yz = clamp_ff.qy * clamp_ff.qz;
      prod_in.wx = clamp_ff.qw * clamp_ff.qx;
      prod_in.wy = clamp_ff.qw * clamp_ff.qy;
      prod_in.wz = clamp_ff.qw * clamp_ff.qz;
      prod_in.px = clamp_ff.px;
      prod_in.py = clamp_ff.py;
      prod_in.pz = clamp_ff.pz;
   end

   always_comb begin
      coef_in.m00 = prod_ff.ww + prod_ff.xx - prod_ff.yy - prod_ff.zz;
      coef_in.m11 = prod_ff.ww - prod_ff.xx + prod_ff.yy - prod_ff.zz;
      coef_in.m22 = prod_ff.ww - prod_ff.xx - prod_ff.yy + prod_ff.zz;
      coef_in.m01 = (prod_ff.xy - prod_ff.wz) <<< 1;
      coef_in.m02 = (prod_ff.xz + prod_ff.wy) <<< 1;
      coef_in.m10 = (prod_ff.xy + prod_ff.wz) <<< 1;
      coef_in.m12 = (prod_ff.yz - prod_ff.wx) <<< 1;
      coef_in.m20 = (prod_ff.xz - prod_ff.wy) <<< 1;
      coef_in.m21 = (prod_ff.yz + prod_ff.wx) <<< 1;
      coef_in.px  = prod_ff.px;
      coef_in.py  = prod_ff.py;
      coef_in.pz  = prod_ff.pz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid;
         if (adv[1]) valid_ff[1] <= valid_ff[0];
         if (adv[2]) valid_ff[2] <= valid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) clamp_ff <= clamp_in;
      if (adv[1]) prod_ff  <= prod_in;
      if (adv[2]) coef_ff  <= coef_in;
   end

   assign out_valid = valid_ff[2];
   assign out_data  = coef_ff;

endmodule

`default_nettype wire

>>> design/qrot_mac.sv
// qrot_mac: multiplies the matrix by the point and sums each row
// two register stages; depends on qrot_pkg
`default_nettype none

module qrot_mac import qrot_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  wire coef_type in_data,
   output logic      out_valid,
   input  wire logic out_ready,
   output sum_type   out_data
);

   logic [1:0] valid_ff;
   logic [1:0] adv;

   term_type term_ff, term_in;
   sum_type  sum_ff, sum_in;

   assign adv[1]   = !valid_ff[1] || out_ready;
   assign adv[0]   = !valid_ff[0] || adv[1];
   assign in_ready = adv[0];

   // one 32x32 product per matrix entry
   always_comb begin
      term_in.t00 = in_data.m00 * in_data.px;
      term_in.t01 = in_data.m01 * in_data.py;
      term_in.t02 = in_data.m02 * in_data.pz;
      term_in.t10 = in_data.m10 * in_data.px;
      term_in.t11 = in_data.m11 * in_data.py;
      term_in.t12 = in_data.m12 * in_data.pz;
      term_in.t20 = in_data.m20 * in_data.px;
      term_in.t21 = in_data.m21 * in_data.py;
      term_in.t22 = in_data.m22 * in_data.pz;
   end

   always_comb begin
      sum_in.sx = term_ff.t00 + term_ff.t01 + term_ff.t02;
      sum_in.sy = term_ff.t10 + term_ff.t11 + term_ff.t12;
      sum_in.sz = term_ff.t20 + term_ff.t21 + term_ff.t22;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid;
         if (adv[1]) valid_ff[1] <= valid_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) term_ff <= term_in;
      if (adv[1]) sum_ff  <= sum_in;
   end

   assign out_valid = valid_ff[1];
   assign out_data  = sum_ff;

endmodule

`default_nettype wire

>>> design/qrot_round.sv
// qrot_round: rounds each row sum to Q16.16 half up and saturates to 32 bits
// one register stage that is also the result register; depends on qrot_pkg
`default_nettype none

module qrot_round import qrot_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  wire sum_type in_data,
   output logic      out_valid,
   input  wire logic out_ready,
   output rsp_type   out_data
);

   logic    valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic signed [RoundWidth-1:0] rnd_x, rnd_y, rnd_z;
   logic                         clip_x, clip_y, clip_z;

   function automatic logic signed [RoundWidth-1:0] round_q(
      input logic signed [TermWidth-1:0] s);
      logic signed [TermWidth:0] t;
      t = {s[TermWidth-1], s} + ROUND_HALF;
      return t[TermWidth:FracShift];
   endfunction

   function automatic logic out_of_range(input logic signed [RoundWidth-1:0] r);
      return !((&r[RoundWidth-1:PointWidth-1]) || !(|r[RoundWidth-1:PointWidth-1]));
   endfunction

   function automatic logic [PointWidth-1:0] clip_q(input logic signed [RoundWidth-1:0] r,
                                                    input logic clip);
      logic [PointWidth-1:0] v;
      v = r[PointWidth-1:0];
      if (clip) begin
         v = r[RoundWidth-1] ? POINT_MIN : POINT_MAX;
      end
      return v;
   endfunction

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      rnd_x      = round_q(in_data.sx);
      rnd_y      = round_q(in_data.sy);
      rnd_z      = round_q(in_data.sz);
      clip_x     = out_of_range(rnd_x);
      clip_y     = out_of_range(rnd_y);
      clip_z     = out_of_range(rnd_z);
      rsp_in.rx  = clip_q(rnd_x, clip_x);
      rsp_in.ry  = clip_q(rnd_y, clip_y);
      rsp_in.rz  = clip_q(rnd_z, clip_z);
      rsp_in.sat = clip_x || clip_y || clip_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

endmodule

`default_nettype wire

>>> design/quaternion_point_rotation_unit.sv
// quaternion_point_rotation_unit: top level of the quaternion point rotation pipeline
// instantiates qrot_coef, qrot_mac and qrot_round; depends on qrot_pkg
//
// rotates a Q16.16 point by a Q1.14 quaternion: vector part of q * (p, 0) * conj(q),
// computed as the equivalent rotation matrix times p, rounded half up and saturated.
// req channel: one transfer carries quat_x/y/z/w and point_x/y/z in req_tdata.
// rsp channel: one transfer per request, rotated_x/y/z in rsp_tdata and the
// saturated flag in rsp_tuser; results leave in request order.
// pipeline: six register stages (clamp, quaternion products, matrix, 32x32 multiplies,
// row sums, rounding), loaded in that order; the req transfer loads the first.
// throughput: one transfer per cycle on both channels while rsp_tready stays high.
// each stage holds its own valid bit and loads whenever it is empty or the next one
// moves, so bubbles close up under a stall and req_tready drops only when every
// stage is full while rsp_tready is low; nothing is lost or repeated.
// reset (synchronous, active high) clears all valid bits; the data registers are not reset.
`default_nettype none

module quaternion_point_rotation_unit import qrot_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [159:0] req_tdata,  // quat_x, quat_y, quat_z, quat_w, point_x, point_y, point_z
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [95:0]       rsp_tdata,  // rotated_x, rotated_y, rotated_z
   output logic              rsp_tuser   // saturated
);

   req_type  req_data;
   coef_type coef_data;
   sum_type  sum_data;
   rsp_type  rsp_data;

   logic coef_valid, coef_ready;
   logic sum_valid, sum_ready;

   assign req_data = req_tdata;

   qrot_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_data),
      .out_valid (coef_valid),
      .out_ready (coef_ready),
      .out_data  (coef_data)
   );

   qrot_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (coef_valid),
      .in_ready  (coef_ready),
      .in_data   (coef_data),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_data  (sum_data)
   );

   qrot_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_data   (sum_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {rsp_data.rz, rsp_data.ry, rsp_data.rx};
   assign rsp_tuser = rsp_data.sat;

endmodule

`default_nettype wire

>>> tb/sv/rotation_checker.sv
// rotation_checker: watches both stream channels of quaternion_point_rotation_unit,
// predicts each rotated point from the accepted request and compares it on the rsp side
// depends on qrot_pkg for the request and response layouts
`timescale 1ns / 1ps

module rotation_checker import qrot_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [159:0] req_tdata,  // quat_x, quat_y, quat_z, quat_w, point_x, point_y, point_z
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [95:0]  rsp_tdata,  // rotated_x, rotated_y, rotated_z
   input  wire logic         rsp_tuser,  // saturated
   output int                items_in,
   output int                items_out,
   output int                sat_count,
   output int                fail_count
);

   localparam longint UnitHigh  = 16384;
   localparam longint UnitLow   = -16384;
   localparam longint PointHigh = 64'sd2147483647;
   localparam longint PointLow  = -64'sd2147483648;

   rsp_type expected_rotations[$];
   rsp_type want;
   rsp_type got;
   int      errs;

   function automatic longint clamp_unit(input logic signed [15:0] q);
      longint v;
      v = q;
      if (v > UnitHigh) begin
         v = UnitHigh;
      end else if (v < UnitLow) begin
         v = UnitLow;
      end
      return v;
   endfunction

   // Q.44 sum to Q16.16, half rounds up, then clip to the point range
   function automatic logic signed [31:0] round_q16(input longint s, inout logic clipped);
      logic signed [64:0] wide;
      longint t;
      wide = {s[63], s};
      wide = wide + 65'sd134217728;
      t = longint'(wide >>> 28);
      if (t > PointHigh) begin
         clipped = 1'b1;
         t = PointHigh;
      end else if (t < PointLow) begin
         clipped = 1'b1;
         t = PointLow;
      end
      return t[31:0];
   endfunction

   function automatic rsp_type rotate_point(input req_type item);
      longint x, y, z, w, px, py, pz;
      longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
      longint sx, sy, sz;
      logic clipped;
      rsp_type r;
      x = clamp_unit(item.qx);
      y = clamp_unit(item.qy);
      z = clamp_unit(item.qz);
      w = clamp_unit(item.qw);
      px = item.px;
      py = item.py;
      pz = item.pz;
      m00 = w * w + x * x - y * y - z * z;
      m01 = 2 * (x * y - w * z);
      m02 = 2 * (x * z + w * y);
      m10 = 2 * (x * y + w * z);
      m11 = w * w - x * x + y * y - z * z;
      m12 = 2 * (y * z - w * x);
      m20 = 2 * (x * z - w * y);
      m21 = 2 * (y * z + w * x);
      m22 = w * w - x * x - y * y + z * z;
      sx = m00 * px + m01 * py + m02 * pz;
      sy = m10 * px + m11 * py + m12 * pz;
      sz = m20 * px + m21 * py + m22 * pz;
      clipped = 1'b0;
      r.rx = round_q16(sx, clipped);
      r.ry = round_q16(sy, clipped);
      r.rz = round_q16(sz, clipped);
      r.sat = clipped;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val, inout int count);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
         count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         items_in   <= 0;
         items_out  <= 0;
         sat_count  <= 0;
         fail_count <= 0;
      end else begin
         errs = 0;
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            if (expected_rotations.size() == 0) begin
               $display("%0t: unexpected rsp transfer, expected none actual %h", $time, got);
               errs++;
            end else begin
               want = expected_rotations.pop_front();
               check_field("rotated_x", want.rx, got.rx, errs);
               check_field("rotated_y", want.ry, got.ry, errs);
               check_field("rotated_z", want.rz, got.rz, errs);
               check_field("saturated", {31'b0, want.sat}, {31'b0, got.sat}, errs);
            end
            items_out <= items_out + 1;
            if (rsp_tuser) begin
               sat_count <= sat_count + 1;
            end
         end
         if (req_tvalid && req_tready) begin
            expected_rotations.push_back(rotate_point(req_type'(req_tdata)));
            items_in <= items_in + 1;
         end
         if (errs != 0) begin
            fail_count <= fail_count + errs;
         end
      end
   end

endmodule

>>> tb/sv/tb_quaternion_point_rotation_unit.sv
// tb_quaternion_point_rotation_unit: stimulus, idle patterns and verdict for the
// quaternion point rotation unit; depends on qrot_pkg and rotation_checker
`timescale 1ns / 1ps

module tb_quaternion_point_rotation_unit;
   import qrot_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int RandomPerPhase = 167;
   localparam logic signed [31:0] PMAX = 32'sh7fffffff;
   localparam logic signed [31:0] PMIN = 32'sh80000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;  // quat_x, quat_y, quat_z, quat_w, point_x, point_y, point_z
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;  // rotated_x, rotated_y, rotated_z
   logic         rsp_tuser;  // saturated

   int items_in, items_out, sat_count, fail_count;
   int send_idle_pct = 26;
   int recv_idle_pct = 58;
   int sent_count = 0;
   int idle_cycles = 0;

   quaternion_point_rotation_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   rotation_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .items_in   (items_in),
      .items_out  (items_out),
      .sat_count  (sat_count),
      .fail_count (fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type make_item(
      input logic signed [15:0] qx, input logic signed [15:0] qy,
      input logic signed [15:0] qz, input logic signed [15:0] qw,
      input logic signed [31:0] px, input logic signed [31:0] py,
      input logic signed [31:0] pz);
      req_type item;
      item.qx = qx;
      item.qy = qy;
      item.qz = qz;
      item.qw = qw;
      item.px = px;
      item.py = py;
      item.pz = pz;
      return item;
   endfunction

   function automatic logic signed [15:0] random_component(input int mode);
      logic signed [15:0] v;
      if (mode < 75) begin
         v = 16'($urandom_range(0, 32768)) - 16'sd16384;
      end else if (mode < 90) begin
         v = 16'($urandom);
      end else begin
         case ($urandom_range(0, 8))
            0: v = -16'sd32768;
            1: v = -16'sd16385;
            2: v = -16'sd16384;
            3: v = -16'sd1;
            4: v = 16'sd0;
            5: v = 16'sd1;
            6: v = 16'sd16384;
            7: v = 16'sd16385;
            default: v = 16'sd32767;
         endcase
      end
      return v;
   endfunction

   function automatic logic signed [31:0] random_coord();
      int mode;
      logic signed [31:0] v;
      mode = $urandom_range(0, 99);
      if (mode < 60) begin
         v = 32'($urandom_range(0, 8388607)) - 32'sd4194304;
      end else if (mode < 90) begin
         v = $urandom;
      end else begin
         case ($urandom_range(0, 4))
            0: v = PMIN;
            1: v = PMAX;
            2: v = 32'sd0;
            3: v = -32'sd1;
            default: v = 32'sd1;
         endcase
      end
      return v;
   endfunction

   function automatic req_type random_item();
      req_type item;
      int mode;
      real a, b, c, d, n;
      mode = $urandom_range(0, 99);
      if (mode < 45) begin
         // unit length quaternion, a proper rotation
         a = $itor($urandom_range(0, 2000)) - 1000.0;
         b = $itor($urandom_range(0, 2000)) - 1000.0;
         c = $itor($urandom_range(0, 2000)) - 1000.0;
         d = $itor($urandom_range(0, 2000)) - 1000.0;
         n = $sqrt(a * a + b * b + c * c + d * d);
         if (n < 1.0) begin
            a = 0.0;
            b = 0.0;
            c = 0.0;
            d = 1.0;
            n = 1.0;
         end
         item.qx = 16'($rtoi(a / n * 16384.0));
         item.qy = 16'($rtoi(b / n * 16384.0));
         item.qz = 16'($rtoi(c / n * 16384.0));
         item.qw = 16'($rtoi(d / n * 16384.0));
      end else begin
         item.qx = random_component(mode);
         item.qy = random_component(mode);
         item.qz = random_component(mode);
         item.qw = random_component(mode);
      end
      item.px = random_coord();
      item.py = random_coord();
      item.pz = random_coord();
      return item;
   endfunction

   task automatic send_point(input req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sent_count++;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // identity, negated identity and simple axis rotations
      send_point(make_item(0, 0, 0, 16384, 32'sd65536, 32'sd131072, -32'sd196608));
      send_point(make_item(0, 0, 0, 16384, PMAX, PMAX, PMAX));
      send_point(make_item(0, 0, 0, 16384, PMIN, PMIN, PMIN));
      send_point(make_item(0, 0, 0, -16384, PMIN, PMAX, 0));
      send_point(make_item(0, 0, 11585, 11585, 32'sd65536, 0, 0));
      send_point(make_item(16384, 0, 0, 0, 1, -1, PMAX));
      send_point(make_item(0, 16384, 0, 0, PMIN, 0, 0));
      send_point(make_item(0, 0, 16384, 0, PMAX, PMAX, PMAX));
      // squared length four, clipped both ways
      send_point(make_item(16384, 16384, 16384, 16384, PMAX, PMAX, PMAX));
      send_point(make_item(-16384, -16384, -16384, -16384, PMIN, PMIN, PMIN));
      // components beyond one are clamped
      send_point(make_item(32767, -32768, 0, 32767, 32'sd65536, 32'sd65536, 32'sd65536));
      send_point(make_item(-32768, -32768, -32768, -32768, 12345, -12345, 777));
      send_point(make_item(16385, -16385, 0, 0, 32'sd65536, -32'sd65536, 32'sd65536));
      send_point(make_item(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, PMAX, PMIN, PMAX));
      // rounding exactly at one half, positive and negative
      send_point(make_item(0, 0, 0, 8192, 2, -2, 6));
      send_point(make_item(0, 0, 0, 8192, -6, 1, -1));
      // zero quaternion, zero point, all ones
      send_point(make_item(0, 0, 0, 0, PMAX, PMIN, PMAX));
      send_point(make_item(9000, -7000, 5000, 11000, 0, 0, 0));
      send_point(make_item(-1, -1, -1, -1, -1, -1, -1));

      repeat (RandomPerPhase) send_point(random_item());
      send_idle_pct = 58;
      recv_idle_pct = 26;
      repeat (RandomPerPhase) send_point(random_item());
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (RandomPerPhase) send_point(random_item());
      req_tvalid <= 1'b0;

      while (items_out < sent_count) begin
         @(posedge clock);
      end
      repeat (12) @(posedge clock);

      $display("rotated %0d points, %0d of them clipped, under three idle patterns",
               items_out, sat_count);
      if (fail_count == 0 && items_out == items_in) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
